// ===== src/circular_deque_top_defines.svh =====
// Assertion macros shared by the circular deque RTL.
`ifndef CIRCULAR_DEQUE_TOP_DEFINES_SVH
`define CIRCULAR_DEQUE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDQ_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cdq_pkg.sv =====
// Shared types and constants of the circular deque.
`default_nettype none

package cdq_pkg;

  localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [1:0] CMD_PUSH_REAR  = 2'd1;
  localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
  localparam logic [1:0] CMD_POP_REAR   = 2'd3;

  localparam int          CAP_W         = 9;
  localparam logic [8:0]  CAP_RESET     = 9'd256;
  localparam logic        REG_CAPACITY  = 1'b0;
  localparam logic [31:0] POP_FAIL_WORD = 32'hFFFF_FFFF;

  // Pointer operation applied by the datapath for one accepted item.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH_FIRST,
    OP_PUSH_FRONT,
    OP_PUSH_REAR,
    OP_POP_FRONT,
    OP_POP_REAR
  } op_t;

  // Source of the popped word in the result cycle.
  typedef enum logic [1:0] {
    RES_ZERO,
    RES_NEG1,
    RES_MEM
  } res_sel_t;

  typedef struct packed {
    op_t      op;
    logic     respond;
    logic     res_ok;
    res_sel_t res_sel;
  } ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stat_t;

endpackage

`default_nettype wire

// ===== src/cdq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/cdq_ctrl.sv =====
// Controller of the circular deque: command decode and result sequencing.
`default_nettype none

module cdq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [1:0]     command,
  input  wire cdq_pkg::stat_t stat,
  output logic                busy,
  output cdq_pkg::ctrl_t      ctrl
);

  import cdq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RESP = 2'b10
  } state_t;

  state_t   state;
  state_t   state_next;
  logic     res_ok;
  logic     res_ok_next;
  res_sel_t res_sel;
  res_sel_t res_sel_next;
  logic     accept;
  op_t      op;

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state == ST_RESP);

  always_comb begin
    op           = OP_NONE;
    res_ok_next  = res_ok;
    res_sel_next = res_sel;
    if (accept) begin
      case (command)
        CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
          res_sel_next = RES_ZERO;
          res_ok_next  = !stat.full;
          if (!stat.full) begin
            if (stat.empty) begin
              op = OP_PUSH_FIRST;
            end else if (command == CMD_PUSH_FRONT) begin
              op = OP_PUSH_FRONT;
            end else begin
              op = OP_PUSH_REAR;
            end
          end
        end
        CMD_POP_FRONT, CMD_POP_REAR: begin
          res_ok_next = !stat.empty;
          if (stat.empty) begin
            res_sel_next = RES_NEG1;
          end else begin
            res_sel_next = RES_MEM;
            op = (command == CMD_POP_FRONT) ? OP_POP_FRONT : OP_POP_REAR;
          end
        end
        default: begin
          op = OP_NONE;
        end
      endcase
    end
  end

  always_comb begin
    case (state)
      ST_IDLE: state_next = accept ? ST_RESP : ST_IDLE;
      ST_RESP: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      res_ok  <= 1'b0;
      res_sel <= RES_ZERO;
    end else begin
      state   <= state_next;
      res_ok  <= res_ok_next;
      res_sel <= res_sel_next;
    end
  end

  assign ctrl.op      = op;
  assign ctrl.respond = (state == ST_RESP);
  assign ctrl.res_ok  = res_ok;
  assign ctrl.res_sel = res_sel;

  `include "circular_deque_top_defines.svh"

  `CDQ_ASSERT_NEXT(a_accept_responds, accept, ctrl.respond, "accepted item got no result cycle")
  `CDQ_ASSERT_SAME(a_pop_mem_ok, ctrl.respond && res_sel == RES_MEM, res_ok, "memory pop without ok")

endmodule

`default_nettype wire

// ===== src/cdq_dpath.sv =====
// Datapath of the circular deque: head/tail pointers, empty flag and store.
`default_nettype none

module cdq_dpath #(
  parameter int DEPTH = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       clear,
  input  wire logic [cdq_pkg::CAP_W-1:0]  capacity,
  input  wire logic signed [31:0]         value,
  input  wire cdq_pkg::ctrl_t             ctrl,
  output cdq_pkg::stat_t                  stat,
  output logic                            done,
  output logic                            ok,
  output logic signed [31:0]              popped,
  output logic                            is_empty,
  output logic                            is_full
);

  import cdq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW = AW + 1;

  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [AW-1:0] tail;
  logic [AW-1:0] tail_next;
  logic          empty;
  logic          empty_next;

  logic [EW-1:0] eff_cap;
  logic [EW-1:0] head_p1;
  logic [EW-1:0] tail_p1;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] tail_inc;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] tail_dec;
  logic [AW-1:0] cap_last;
  logic          full;

  logic          we;
  logic [AW-1:0] waddr;
  logic          re;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;

  // A capacity of zero acts as one; anything above the store size acts as the size.
  always_comb begin
    if (capacity == '0) begin
      eff_cap = EW'(1);
    end else if (32'(capacity) > 32'(DEPTH)) begin
      eff_cap = EW'(DEPTH);
    end else begin
      eff_cap = EW'(capacity);
    end
  end

  assign cap_last = AW'(eff_cap - EW'(1));
  assign head_p1  = {1'b0, head} + EW'(1);
  assign tail_p1  = {1'b0, tail} + EW'(1);
  assign head_inc = (head_p1 >= eff_cap) ? '0 : head_p1[AW-1:0];
  assign tail_inc = (tail_p1 >= eff_cap) ? '0 : tail_p1[AW-1:0];
  assign head_dec = (head == '0) ? cap_last : head - AW'(1);
  assign tail_dec = (tail == '0) ? cap_last : tail - AW'(1);
  assign full     = !empty && (tail_inc == head);

  assign stat.empty = empty;
  assign stat.full  = full;

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    re    = 1'b0;
    raddr = tail;
    case (ctrl.op)
      OP_PUSH_FIRST: begin
        we = 1'b1;
      end
      OP_PUSH_FRONT: begin
        we    = 1'b1;
        waddr = head_dec;
      end
      OP_PUSH_REAR: begin
        we    = 1'b1;
        waddr = tail_inc;
      end
      OP_POP_FRONT: begin
        re    = 1'b1;
        raddr = head;
      end
      OP_POP_REAR: begin
        re = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    empty_next = empty;
    if (clear) begin
      head_next  = '0;
      tail_next  = '0;
      empty_next = 1'b1;
    end else begin
      case (ctrl.op)
        OP_PUSH_FIRST: begin
          head_next  = '0;
          tail_next  = '0;
          empty_next = 1'b0;
        end
        OP_PUSH_FRONT: head_next = head_dec;
        OP_PUSH_REAR:  tail_next = tail_inc;
        OP_POP_FRONT, OP_POP_REAR: begin
          // Removing the only element returns the queue to its reset layout.
          if (head == tail) begin
            head_next  = '0;
            tail_next  = '0;
            empty_next = 1'b1;
          end else if (ctrl.op == OP_POP_FRONT) begin
            head_next = head_inc;
          end else begin
            tail_next = tail_dec;
          end
        end
        default: begin
          empty_next = empty;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      empty <= 1'b1;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      empty <= empty_next;
    end
  end

  cdq_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (value),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    case (ctrl.res_sel)
      RES_MEM:  popped = rdata;
      RES_NEG1: popped = POP_FAIL_WORD;
      default:  popped = '0;
    endcase
  end

  assign done     = ctrl.respond;
  assign ok       = ctrl.res_ok;
  assign is_empty = empty;
  assign is_full  = full;

  `include "circular_deque_top_defines.svh"

  `CDQ_ASSERT_SAME(a_ptr_in_range, 1'b1, ({1'b0, head} < eff_cap) && ({1'b0, tail} < eff_cap), "pointer beyond capacity")
  `CDQ_ASSERT_SAME(a_empty_layout, empty, (head == '0) && (tail == '0), "empty queue with moved pointers")
  `CDQ_ASSERT_SAME(a_one_access, 1'b1, !(we && re), "store written and read in one transfer")

endmodule

`default_nettype wire

// ===== src/circular_deque_top.sv =====
// Top level of the circular deque: configuration port, controller and datapath.
//
// A double-ended queue of signed 32-bit words in a circular store of DEPTH
// entries, of which the capacity register selects how many are used. An item
// is taken when start is high and busy is low; its result appears in the cycle
// right after the item is taken, as one transfer marked by done that the receiver
// must take in that cycle, since it cannot be held off. An item updates the
// pointers and issues the store access when it is taken, and the registered
// read of the store completes in the result cycle, in which busy is high. Writing
// the capacity register empties the queue; write it only while idle.
`default_nettype none

module circular_deque_top #(
  parameter int DEPTH = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         command,
  input  wire logic signed [31:0] value,
  output logic                    done,
  output logic                    ok,
  output logic signed [31:0]      popped,
  output logic                    is_empty,
  output logic                    is_full
);

  import cdq_pkg::*;

  logic [CAP_W-1:0] capacity;
  logic             cap_wr;
  ctrl_t            ctrl;
  stat_t            stat;

  assign pready = 1'b1;
  assign cap_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32 - CAP_W){1'b0}}, capacity} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cap_wr) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  cdq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .busy    (busy),
    .ctrl    (ctrl)
  );

  cdq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .clear    (cap_wr),
    .capacity (capacity),
    .value    (value),
    .ctrl     (ctrl),
    .stat     (stat),
    .done     (done),
    .ok       (ok),
    .popped   (popped),
    .is_empty (is_empty),
    .is_full  (is_full)
  );

  `include "circular_deque_top_defines.svh"

  `CDQ_ASSERT_SAME(a_done_busy, done, busy, "result transfer outside the busy cycle")

endmodule

`default_nettype wire

// ===== sim/deque_checker.sv =====
// Checker for the circular deque: predicts each result and compares it with the block.
`timescale 1ns / 1ps

module deque_checker #(
  parameter int         DEPTH    = 256,
  parameter logic [2:0] CAP_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  command,
  input  logic [31:0] value,
  input  logic        done,
  input  logic        ok,
  input  logic [31:0] popped,
  input  logic        is_empty,
  input  logic        is_full,
  output int          mismatches,
  output int          outstanding
);

  import cdq_pkg::*;

  typedef struct packed {
    logic        ok;
    logic [31:0] popped;
    logic        empty;
    logic        full;
  } deque_result_t;

  logic [31:0]   words [DEPTH];
  int unsigned   front_ptr;
  int unsigned   rear_ptr;
  logic          queue_empty;
  logic [8:0]    capacity;
  deque_result_t expected_q [$];
  int            mismatch_count;

  // A capacity of zero acts as one, and anything above the store size acts as the store size.
  function automatic int unsigned usable_entries();
    if (capacity == 9'd0) return 1;
    if (capacity > DEPTH) return DEPTH;
    return capacity;
  endfunction

  function automatic int unsigned step_fwd(input int unsigned idx);
    return (idx + 1 >= usable_entries()) ? 0 : idx + 1;
  endfunction

  function automatic int unsigned step_back(input int unsigned idx);
    return (idx == 0 || idx > usable_entries()) ? usable_entries() - 1 : idx - 1;
  endfunction

  function automatic logic queue_full();
    return !queue_empty && step_fwd(rear_ptr) == front_ptr;
  endfunction

  function automatic void clear_queue();
    front_ptr   = 0;
    rear_ptr    = 0;
    queue_empty = 1'b1;
  endfunction

  function automatic deque_result_t apply_command(input logic [1:0] cmd,
                                                  input logic [31:0] word);
    deque_result_t res;
    res = '0;
    if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_REAR) begin
      if (!queue_full()) begin
        // The first word into an empty queue always lands at index zero.
        if (queue_empty) begin
          front_ptr   = 0;
          rear_ptr    = 0;
          queue_empty = 1'b0;
          words[0]    = word;
        end else if (cmd == CMD_PUSH_FRONT) begin
          front_ptr        = step_back(front_ptr);
          words[front_ptr] = word;
        end else begin
          rear_ptr        = step_fwd(rear_ptr);
          words[rear_ptr] = word;
        end
        res.ok = 1'b1;
      end
    end else if (queue_empty) begin
      res.popped = POP_FAIL_WORD;
    end else begin
      res.popped = (cmd == CMD_POP_FRONT) ? words[front_ptr] : words[rear_ptr];
      if (front_ptr == rear_ptr) begin
        clear_queue();
      end else if (cmd == CMD_POP_FRONT) begin
        front_ptr = step_fwd(front_ptr);
      end else begin
        rear_ptr = step_back(rear_ptr);
      end
      res.ok = 1'b1;
    end
    res.empty = queue_empty;
    res.full  = queue_full();
    return res;
  endfunction

  always @(posedge clk) begin
    deque_result_t want;
    if (rst) begin
      capacity = CAP_RESET;
      clear_queue();
      expected_q.delete();
      mismatch_count = 0;
    end else begin
      // Any capacity write rebuilds the queue empty.
      if (psel && penable && pwrite && pready && paddr == CAP_ADDR) begin
        capacity = pwdata[8:0];
        clear_queue();
      end
      if (start && !busy) expected_q.push_back(apply_command(command, value));
      if (done) begin
        if (expected_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] result transfer with nothing outstanding: ok=%0b popped=%h",
                     $realtime, ok, popped);
        end else begin
          want = expected_q[0];
          expected_q.delete(0);
          if (ok !== want.ok || popped !== want.popped ||
              is_empty !== want.empty || is_full !== want.full) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("[%0t] result mismatch: expected ok=%0b popped=%h empty=%0b full=%0b",
                       $realtime, want.ok, want.popped, want.empty, want.full);
              $display("    got ok=%0b popped=%h empty=%0b full=%0b",
                       ok, popped, is_empty, is_full);
            end
          end
        end
      end
    end
    mismatches  <= mismatch_count;
    outstanding <= expected_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the circular deque: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import cdq_pkg::*;

  localparam logic [2:0] CAP_ADDR    = {REG_CAPACITY, 2'b00};
  localparam int         STALL_LIMIT = 2000;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               start;
  logic               busy;
  logic [1:0]         command;
  logic signed [31:0] value;
  logic               done;
  logic               ok;
  logic signed [31:0] popped;
  logic               is_empty;
  logic               is_full;
  int                 mismatches;
  int                 outstanding;
  int                 idle_pct;
  int                 quiet_cycles = 0;

  circular_deque_top #(.DEPTH(256)) u_top (.*);

  deque_checker #(.DEPTH(256), .CAP_ADDR(CAP_ADDR)) u_checker (.*);

  always #1 clk = ~clk;

  // Ends the run when neither an item nor a result transfer happens for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_capacity(input logic [31:0] word);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Returns at the edge where the item transfer takes place.
  task automatic issue(input logic [1:0] cmd, input logic [31:0] word);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start   <= 1'b1;
    command <= cmd;
    value   <= word;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(input int count, input int push_pct, input int gap_pct);
    logic [1:0] cmd;
    idle_pct = gap_pct;
    repeat (count) begin
      if ($urandom_range(99) < push_pct)
        cmd = $urandom_range(1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
      else
        cmd = $urandom_range(1) ? CMD_POP_REAR : CMD_POP_FRONT;
      issue(cmd, $urandom);
    end
    drain();
  endtask

  initial begin
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    start    = 1'b0;
    command  = CMD_PUSH_FRONT;
    value    = '0;
    idle_pct = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Three entries: empty pops, fill to full, pushes refused, drain from both ends.
    write_capacity(32'd3);
    issue(CMD_POP_FRONT,  32'h0000_0000);
    issue(CMD_POP_REAR,   32'h1234_5678);
    issue(CMD_PUSH_REAR,  32'h7FFF_FFFF);
    issue(CMD_PUSH_FRONT, 32'h8000_0000);
    issue(CMD_PUSH_REAR,  32'h0000_0000);
    issue(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    issue(CMD_PUSH_REAR,  32'h0000_0001);
    issue(CMD_POP_FRONT,  32'hFFFF_FFFF);
    issue(CMD_POP_REAR,   32'h0000_0000);
    issue(CMD_POP_REAR,   32'h0000_0000);
    issue(CMD_POP_FRONT,  32'h0000_0000);
    issue(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    issue(CMD_PUSH_FRONT, 32'h5555_5555);
    issue(CMD_POP_REAR,   32'h0000_0000);
    issue(CMD_POP_FRONT,  32'h0000_0000);
    drain();

    // A zero capacity behaves as a single entry.
    write_capacity(32'd0);
    issue(CMD_PUSH_REAR,  32'hAAAA_AAAA);
    issue(CMD_PUSH_FRONT, 32'h0F0F_0F0F);
    issue(CMD_POP_REAR,   32'h0000_0000);
    issue(CMD_POP_REAR,   32'h0000_0000);
    issue(CMD_PUSH_FRONT, 32'h1234_5678);
    issue(CMD_POP_FRONT,  32'h0000_0000);
    drain();

    write_capacity(32'd256);
    random_phase(25, 70, 0);
    write_capacity(32'd1);
    random_phase(20, 50, 79);
    write_capacity(32'd2);
    random_phase(25, 55, 27);
    write_capacity(32'd5);
    random_phase(30, 55, 0);
    write_capacity(32'd17);
    random_phase(40, 65, 79);
    write_capacity($urandom_range(40, 3));
    random_phase(30, 60, 27);

    // All ones: the register keeps nine bits, which is above the store size.
    // Filling it reaches full and refuses the last pushes.
    write_capacity(32'hFFFF_FFFF);
    random_phase(258, 100, 0);
    random_phase(8, 0, 27);

    write_capacity($urandom_range(256, 1));
    random_phase(20, 50, 79);

    if (mismatches == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
